### src/izh_pkg.sv
// ----------------------------------------------------------------------------
// izh_pkg
// Shared types, constants and fixed-point helpers for the neuron step block.
// ----------------------------------------------------------------------------
package izh_pkg;

  localparam int unsigned CFG_IDX_W = 4;

  // potential above which a spike is flagged, signed q16.16
  localparam logic signed [31:0] PEAK_V = 32'sd3276800;

  // state after reset
  localparam logic signed [31:0] MEMBRANE_V_RST = -32'sd4259840;
  localparam logic signed [31:0] RECOVERY_U_RST = -32'sd21299200;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_STEP_OVER_CAP = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_K_GAIN        = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REST_V        = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH_V      = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RESET_V       = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RECOVERY_JUMP = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_A        = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_RECOVERY_SENS = 4'd7;

  // register reset values
  localparam logic [31:0] STEP_OVER_CAP_RST = 32'd4294967;
  localparam logic [31:0] K_GAIN_RST        = 32'd196608;
  localparam logic [31:0] REST_V_RST        = 32'hFFC4_0000;
  localparam logic [31:0] THRESH_V_RST      = 32'hFFCE_0000;
  localparam logic [31:0] RESET_V_RST       = 32'hFFC4_0000;
  localparam logic [31:0] RECOVERY_JUMP_RST = 32'd26214400;
  localparam logic [31:0] STEP_A_RST        = 32'd4294967;
  localparam logic [31:0] RECOVERY_SENS_RST = 32'd327680;

  // width of the product register of the shared 33x33 multiplier
  localparam int unsigned PROD_W = 66;

  localparam logic signed [PROD_W-1:0] SAT_MAX = 66'sd2147483647;
  localparam logic signed [PROD_W-1:0] SAT_MIN = -66'sd2147483648;
  localparam logic signed [PROD_W-1:0] RND16   = 66'sd32768;
  localparam logic signed [PROD_W-1:0] RND32   = 66'sd2147483648;

  typedef struct packed {
    logic [31:0] step_over_cap;
    logic [31:0] k_gain;
    logic [31:0] rest_v;
    logic [31:0] thresh_v;
    logic [31:0] reset_v;
    logic [31:0] recovery_jump;
    logic [31:0] step_a;
    logic [31:0] recovery_sens;
  } cfg_t;

  // one datapath operation per cycle, issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_DD,
    OP_MUL_K,
    OP_MUL_DRIVE,
    OP_NEW_V,
    OP_MUL_B,
    OP_MUL_DU,
    OP_FINISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  // clamp a wide signed value to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] x);
    logic signed [31:0] r;
    if (x > SAT_MAX) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < SAT_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

### src/izhikevich_neuron_step.sv
// ----------------------------------------------------------------------------
// izhikevich_neuron_step
// One forward-Euler tick of the quadratic spiking neuron per input request.
// ----------------------------------------------------------------------------
// Each request carries the total input current of one tick (signed q16.16) and
// gives one result: the spike flag on m_tuser and the recorded potential on
// m_tdata. A new request is taken only once the previous tick has finished.
// A tick loads the differences on acceptance, then runs the five dependent
// products one after another through a single 33x33 multiplier, forming the
// new v after the third product, and then finishes. A
// result waiting in the output register does not stop the next tick from
// starting, but that tick holds in its finishing step until the waiting
// result is taken. Configuration writes are taken in any cycle, always ready,
// and are meant for idle periods only.
module izhikevich_neuron_step (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [31:0]                    s_tdata,    // [31:0] input_current
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [31:0]                    m_tdata,    // [31:0] recorded_v
  output logic                           m_tuser,    // [0] spiked
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [izh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                    cfg_data
);

  izh_pkg::cfg_t    cfg;
  izh_pkg::dp_cmd_t cmd;

  assign cfg_ready = 1'b1;

  izh_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  izh_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .cmd       (cmd)
  );

  izh_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .cfg        (cfg),
    .in_current (s_tdata),
    .res_spiked (m_tuser),
    .res_v      (m_tdata)
  );

endmodule

### src/izh_cfg.sv
// ----------------------------------------------------------------------------
// izh_cfg
// Configuration register file, written through the index/data request channel.
// ----------------------------------------------------------------------------
module izh_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [izh_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [31:0]                    wr_data,
  output izh_pkg::cfg_t                  cfg
);

  izh_pkg::cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.step_over_cap <= izh_pkg::STEP_OVER_CAP_RST;
      regs.k_gain        <= izh_pkg::K_GAIN_RST;
      regs.rest_v        <= izh_pkg::REST_V_RST;
      regs.thresh_v      <= izh_pkg::THRESH_V_RST;
      regs.reset_v       <= izh_pkg::RESET_V_RST;
      regs.recovery_jump <= izh_pkg::RECOVERY_JUMP_RST;
      regs.step_a        <= izh_pkg::STEP_A_RST;
      regs.recovery_sens <= izh_pkg::RECOVERY_SENS_RST;
    end else if (wr_en) begin
      case (wr_index)
        izh_pkg::REG_STEP_OVER_CAP: regs.step_over_cap <= wr_data;
        izh_pkg::REG_K_GAIN:        regs.k_gain        <= wr_data;
        izh_pkg::REG_REST_V:        regs.rest_v        <= wr_data;
        izh_pkg::REG_THRESH_V:      regs.thresh_v      <= wr_data;
        izh_pkg::REG_RESET_V:       regs.reset_v       <= wr_data;
        izh_pkg::REG_RECOVERY_JUMP: regs.recovery_jump <= wr_data;
        izh_pkg::REG_STEP_A:        regs.step_a        <= wr_data;
        izh_pkg::REG_RECOVERY_SENS: regs.recovery_sens <= wr_data;
        default: ; // unknown index, write dropped
      endcase
    end
  end

  assign cfg = regs;

endmodule

### src/izh_dp.sv
// ----------------------------------------------------------------------------
// izh_dp
// Neuron datapath: v and u state, one shared 33x33 multiplier with a product
// register, rounding and saturation, and the result register.
// ----------------------------------------------------------------------------
module izh_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  izh_pkg::dp_cmd_t     cmd,
  input  izh_pkg::cfg_t        cfg,
  input  logic [31:0]          in_current,
  output logic                 res_spiked,
  output logic [31:0]          res_v
);

  // loop-carried state
  logic signed [31:0] membrane_v;
  logic signed [31:0] recovery_u;

  // per-tick working registers
  logic signed [31:0] cur;
  logic signed [31:0] dr;
  logic signed [31:0] dt;
  logic signed [31:0] nv;
  logic signed [31:0] rv;
  logic signed [izh_pkg::PROD_W-1:0] prod;

  // result register
  logic               spk;
  logic signed [31:0] rec_v;

  logic signed [31:0] k_gain;
  logic signed [31:0] rest_v;
  logic signed [31:0] thresh_v;
  logic signed [31:0] reset_v;
  logic signed [31:0] recovery_jump;
  logic signed [31:0] recovery_sens;

  logic signed [31:0] t16;
  logic signed [31:0] t32;
  logic signed [31:0] drive;
  logic signed [31:0] du;
  logic signed [31:0] nv_next;
  logic signed [31:0] nu;
  logic signed [31:0] nu_jump;
  logic               spike;
  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;

  assign k_gain        = $signed(cfg.k_gain);
  assign rest_v        = $signed(cfg.rest_v);
  assign thresh_v      = $signed(cfg.thresh_v);
  assign reset_v       = $signed(cfg.reset_v);
  assign recovery_jump = $signed(cfg.recovery_jump);
  assign recovery_sens = $signed(cfg.recovery_sens);

  // round to nearest, ties up, then clamp
  assign t16 = izh_pkg::sat32((prod + izh_pkg::RND16) >>> 16);
  assign t32 = izh_pkg::sat32((prod + izh_pkg::RND32) >>> 32);

  assign drive   = izh_pkg::sat32(66'(t16) - 66'(recovery_u) + 66'(cur));
  assign du      = izh_pkg::sat32(66'(t16) - 66'(recovery_u));
  assign nv_next = izh_pkg::sat32(66'(membrane_v) + 66'(t32));
  assign nu      = izh_pkg::sat32(66'(recovery_u) + 66'(t32));
  assign nu_jump = izh_pkg::sat32(66'(nu) + 66'(recovery_jump));
  assign spike   = (nv > izh_pkg::PEAK_V);

  // operand selection for the shared multiplier; rates are unsigned q0.32
  always_comb begin
    case (cmd.op)
      izh_pkg::OP_MUL_DD: begin
        mul_a = 33'(dr);
        mul_b = 33'(dt);
      end
      izh_pkg::OP_MUL_K: begin
        mul_a = 33'(k_gain);
        mul_b = 33'(t16);
      end
      izh_pkg::OP_MUL_DRIVE: begin
        mul_a = 33'(drive);
        mul_b = $signed({1'b0, cfg.step_over_cap});
      end
      izh_pkg::OP_MUL_B: begin
        mul_a = 33'(recovery_sens);
        mul_b = 33'(rv);
      end
      izh_pkg::OP_MUL_DU: begin
        mul_a = 33'(du);
        mul_b = $signed({1'b0, cfg.step_a});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      izh_pkg::OP_MUL_DD,
      izh_pkg::OP_MUL_K,
      izh_pkg::OP_MUL_DRIVE,
      izh_pkg::OP_MUL_B,
      izh_pkg::OP_MUL_DU: prod <= 66'(mul_a) * 66'(mul_b);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      izh_pkg::OP_LOAD: begin
        cur <= $signed(in_current);
        dr  <= izh_pkg::sat32(66'(membrane_v) - 66'(rest_v));
        dt  <= izh_pkg::sat32(66'(membrane_v) - 66'(thresh_v));
      end
      izh_pkg::OP_NEW_V: begin
        nv <= nv_next;
        rv <= izh_pkg::sat32(66'(nv_next) - 66'(rest_v));
      end
      izh_pkg::OP_FINISH: begin
        spk   <= spike;
        rec_v <= spike ? izh_pkg::PEAK_V : nv;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      membrane_v <= izh_pkg::MEMBRANE_V_RST;
      recovery_u <= izh_pkg::RECOVERY_U_RST;
    end else if (cmd.op == izh_pkg::OP_FINISH) begin
      membrane_v <= spike ? reset_v : nv;
      recovery_u <= spike ? nu_jump : nu;
    end
  end

  assign res_spiked = spk;
  assign res_v      = rec_v;

endmodule

### src/izh_ctrl.sv
// ----------------------------------------------------------------------------
// izh_ctrl
// Tick sequencer: steps the datapath through its multiplies and owns the
// input and result handshakes.
// ----------------------------------------------------------------------------
module izh_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output izh_pkg::dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_DD,
    ST_MUL_K,
    ST_MUL_DRIVE,
    ST_NEW_V,
    ST_MUL_B,
    ST_MUL_DU,
    ST_FINISH
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;
  logic   finish;

  // the result register can be loaded when empty or being drained
  assign out_free = !out_valid || out_ready;
  assign finish   = (state == ST_FINISH) && out_free;
  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd.op     = izh_pkg::OP_NONE;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op     = izh_pkg::OP_LOAD;
          state_next = ST_MUL_DD;
        end
      end
      ST_MUL_DD: begin
        cmd.op     = izh_pkg::OP_MUL_DD;
        state_next = ST_MUL_K;
      end
      ST_MUL_K: begin
        cmd.op     = izh_pkg::OP_MUL_K;
        state_next = ST_MUL_DRIVE;
      end
      ST_MUL_DRIVE: begin
        cmd.op     = izh_pkg::OP_MUL_DRIVE;
        state_next = ST_NEW_V;
      end
      ST_NEW_V: begin
        cmd.op     = izh_pkg::OP_NEW_V;
        state_next = ST_MUL_B;
      end
      ST_MUL_B: begin
        cmd.op     = izh_pkg::OP_MUL_B;
        state_next = ST_MUL_DU;
      end
      ST_MUL_DU: begin
        cmd.op     = izh_pkg::OP_MUL_DU;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (finish) begin
          cmd.op     = izh_pkg::OP_FINISH;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // a new result only ever comes out of the finishing step
  a_result_from_finish: assert property (
    @(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_FINISH)
  ) else $error("result appeared without a finishing step");

  // a blocked result holds the tick in its finishing step
  a_finish_waits: assert property (
    @(posedge clk) disable iff (rst)
    (state == ST_FINISH && out_valid && !out_ready) |=> (state == ST_FINISH && out_valid)
  ) else $error("finishing step overran a waiting result");

  // one tick at a time: an accepted request blocks the next one
  a_single_tick: assert property (
    @(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (!in_ready && state == ST_MUL_DD)
  ) else $error("request accepted while a tick was in flight");

endmodule
